### sv/background_subtract_color_classify_top_assert.svh
// Assertion macros used by the background subtract color classifier top level.
`ifndef BACKGROUND_SUBTRACT_COLOR_CLASSIFY_TOP_ASSERT_SVH
`define BACKGROUND_SUBTRACT_COLOR_CLASSIFY_TOP_ASSERT_SVH

// Check that lhs implies rhs in the same cycle.
`define BSCC_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("bscc: same-cycle check failed");

// Check that lhs implies rhs in the next cycle.
`define BSCC_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("bscc: next-cycle check failed");

`endif

### sv/bscc_pkg.sv
// Types and constants of the background subtract color classifier.
`timescale 1ns / 1ps

package bscc_pkg;

    localparam int ROW_W       = 9;
    localparam int COL_W       = 10;
    localparam int ROWB_W      = 11;
    localparam int COLB_W      = 12;
    localparam int BAND_W      = 22;
    localparam int SPAN_W      = 10;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 22;
    localparam int ROW_MARGIN  = 15;
    localparam int PAL_AW      = 15;
    localparam int PAL_DW      = 8;
    localparam int PAL_DEPTH   = 1 << PAL_AW;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int SETTLE_W    = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_TOP_ROW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BOTTOM_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEFT_COL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RIGHT_COL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_LEFT_COL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RIGHT_COL   = 3'd6;

    localparam logic [7:0]       RST_DIFF_THRESHOLD   = 8'd0;
    localparam logic [ROW_W-1:0] RST_FIELD_TOP_ROW    = 9'd10;
    localparam logic [ROW_W-1:0] RST_FIELD_BOTTOM_ROW = 9'd460;
    localparam logic [COL_W-1:0] RST_INNER_LEFT_COL   = 10'd10;
    localparam logic [COL_W-1:0] RST_INNER_RIGHT_COL  = 10'd620;
    localparam logic [COL_W-1:0] RST_GOAL_LEFT_COL    = 10'd72;
    localparam logic [COL_W-1:0] RST_GOAL_RIGHT_COL   = 10'd550;

    localparam logic ACTION_CLASSIFY = 1'b0;
    localparam logic ACTION_WRITE    = 1'b1;

    typedef struct packed {
        logic              action;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        bg_red;
        logic [7:0]        bg_green;
        logic [7:0]        bg_blue;
        logic [PAL_AW-1:0] palette_addr;
        logic [PAL_DW-1:0] palette_data;
    } pixel_in_t;

    typedef struct packed {
        logic [PAL_DW-1:0] color_class;
        logic              is_sentinel;
        logic              is_no_color;
        logic              frame_last;
    } pixel_out_t;

    typedef struct packed {
        logic signed [ROWB_W-1:0] lo;
        logic signed [ROWB_W-1:0] hi;
        logic signed [BAND_W-1:0] gs;
        logic signed [BAND_W-1:0] ge;
        logic signed [COLB_W-1:0] inner_left;
        logic signed [COLB_W-1:0] inner_right;
        logic signed [COLB_W-1:0] goal_left;
        logic signed [COLB_W-1:0] goal_right;
        logic [7:0]               threshold;
        logic                     settled;
    } window_t;

endpackage

### sv/background_subtract_color_classify_top.sv
// Top level of the background subtract color classifier.
`timescale 1ns / 1ps
// Takes at most one word per cycle on the pix channel. A classify word yields one
// registered result word on the res channel; a palette write word updates the
// 32768-entry palette in its accept cycle and yields nothing. The palette is a
// single-port-read, single-port-write memory read at accept, so a write is seen by
// the very next pixel. Palette entries are undefined until written and have no
// clearing pass. After reset and after every configuration write, pix_ready stays
// low while the goal band bounds settle through the window unit's multiplier stages;
// otherwise the sustained rate is one word per cycle, stalled only by res_ready.
`include "background_subtract_color_classify_top_assert.svh"

module background_subtract_color_classify_top #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int FIELD_HEIGHT = 130,
    parameter int GOAL_HEIGHT  = 40,
    parameter int EDGE_GAP     = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  bscc_pkg::pixel_in_t             pix,
    output logic                            res_valid,
    input  logic                            res_ready,
    output bscc_pkg::pixel_out_t            res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bscc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bscc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W  = bscc_pkg::ROW_W;
    localparam int COL_W  = bscc_pkg::COL_W;
    localparam int ROWB_W = bscc_pkg::ROWB_W;
    localparam int COLB_W = bscc_pkg::COLB_W;
    localparam int BAND_W = bscc_pkg::BAND_W;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);

    bscc_pkg::window_t win;

    logic accept, cls_accept, wr_accept, out_free, s1_take;
    logic cfg_wr;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [7:0]           s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [7:0]           s1_bgr_reg, s1_bgg_reg, s1_bgb_reg;
    logic [bscc_pkg::PAL_DW-1:0] pal_rdata;
    logic [bscc_pkg::PAL_AW-1:0] pal_raddr;

    logic                 res_valid_reg;
    bscc_pkg::pixel_out_t res_reg, res_next;

    logic signed [ROWB_W-1:0] row_w;
    logic signed [BAND_W-1:0] row_b;
    logic signed [COLB_W-1:0] col_b, left, right;
    logic sent, in_band, col_out, fg;

    function automatic logic exceeds(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] th);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > th;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    bscc_window #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .FIELD_HEIGHT (FIELD_HEIGHT),
        .GOAL_HEIGHT  (GOAL_HEIGHT),
        .EDGE_GAP     (EDGE_GAP)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .win      (win)
    );

    assign pal_raddr = {pix.red[7:3], pix.green[7:3], pix.blue[7:3]};

    bscc_palette_ram u_palette (
        .clk   (clk),
        .we    (wr_accept),
        .waddr (pix.palette_addr),
        .wdata (pix.palette_data),
        .re    (cls_accept),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    assign out_free   = !res_valid_reg || res_ready;
    assign s1_take    = !s1_valid_reg || out_free;
    assign pix_ready  = win.settled && s1_take;
    assign accept     = pix_valid && pix_ready;
    assign cls_accept = accept && (pix.action == bscc_pkg::ACTION_CLASSIFY);
    assign wr_accept  = accept && (pix.action == bscc_pkg::ACTION_WRITE);

    // advance raster position
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cls_accept)
        begin
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = (row_reg == ROW_LAST) ? '0 : (row_reg + 1'b1);
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (cls_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            if (out_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_accept)
        begin
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_red_reg   <= pix.red;
            s1_green_reg <= pix.green;
            s1_blue_reg  <= pix.blue;
            s1_bgr_reg   <= pix.bg_red;
            s1_bgg_reg   <= pix.bg_green;
            s1_bgb_reg   <= pix.bg_blue;
        end
        if (out_free && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // classify the held pixel
    always_comb
    begin
        row_w   = signed'(ROWB_W'(s1_row_reg));
        row_b   = signed'(BAND_W'(s1_row_reg));
        col_b   = signed'(COLB_W'(s1_col_reg));
        sent    = (row_w < win.lo) || (row_w >= win.hi);
        in_band = (row_b >= win.gs) && (row_b < win.ge);
        left    = in_band ? win.goal_left  : win.inner_left;
        right   = in_band ? win.goal_right : win.inner_right;
        col_out = (col_b < left) || (col_b >= right);
        fg      = exceeds(s1_red_reg,   s1_bgr_reg, win.threshold)
               || exceeds(s1_green_reg, s1_bgg_reg, win.threshold)
               || exceeds(s1_blue_reg,  s1_bgb_reg, win.threshold);

        res_next.color_class = '0;
        res_next.is_sentinel = 1'b0;
        res_next.is_no_color = 1'b0;
        res_next.frame_last  = (s1_row_reg == ROW_LAST) && (s1_col_reg == COL_LAST);
        if (sent)
        begin
            res_next.is_sentinel = 1'b1;
        end
        else if (col_out || !fg)
        begin
            res_next.is_no_color = 1'b1;
        end
        else
        begin
            res_next.color_class = pal_rdata;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `BSCC_ASSERT_NXT(a_cls_enters_s1, cls_accept, s1_valid_reg)
    `BSCC_ASSERT_NXT(a_col_wraps, cls_accept && (col_reg == COL_LAST), col_reg == '0)
    `BSCC_ASSERT_IMP(a_flag_zero_class,
        res_valid_reg && (res_reg.is_sentinel || res_reg.is_no_color),
        res_reg.color_class == '0)
    `BSCC_ASSERT_NXT(a_cfg_holds_pix, cfg_wr, !pix_ready)

endmodule

### sv/bscc_palette_ram.sv
// Color palette memory, one write port and one registered read port.
`timescale 1ns / 1ps

module bscc_palette_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [bscc_pkg::PAL_AW-1:0] waddr,
    input  logic [bscc_pkg::PAL_DW-1:0] wdata,
    input  logic                        re,
    input  logic [bscc_pkg::PAL_AW-1:0] raddr,
    output logic [bscc_pkg::PAL_DW-1:0] rdata
);

    logic [bscc_pkg::PAL_DW-1:0] mem [bscc_pkg::PAL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/bscc_window.sv
// Configuration registers and derived row, band and column window bounds.
`timescale 1ns / 1ps

module bscc_window #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int FIELD_HEIGHT = 130,
    parameter int GOAL_HEIGHT  = 40,
    parameter int EDGE_GAP     = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bscc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bscc_pkg::CFG_DATA_W-1:0] wr_data,
    output bscc_pkg::window_t               win
);

    localparam int ROWB_W  = bscc_pkg::ROWB_W;
    localparam int COLB_W  = bscc_pkg::COLB_W;
    localparam int BAND_W  = bscc_pkg::BAND_W;
    localparam int SPAN_W  = bscc_pkg::SPAN_W;
    localparam int RECIP_W = bscc_pkg::RECIP_W;
    localparam int PROD_W  = SPAN_W + RECIP_W;

    localparam longint GOAL_DIFF = longint'(FIELD_HEIGHT) - longint'(GOAL_HEIGHT);
    localparam longint GOAL_ABS  = (GOAL_DIFF < 0) ? -GOAL_DIFF : GOAL_DIFF;
    localparam longint START_DIV = 2 * longint'(FIELD_HEIGHT);
    localparam longint START_MUL =
        ((GOAL_ABS << bscc_pkg::RECIP_SHIFT) + START_DIV - 1) / START_DIV;
    localparam longint LEN_MUL =
        ((longint'(GOAL_HEIGHT) << bscc_pkg::RECIP_SHIFT) + longint'(FIELD_HEIGHT) - 1)
        / longint'(FIELD_HEIGHT);
    localparam logic [RECIP_W-1:0] START_MUL_C = START_MUL[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] LEN_MUL_C   = LEN_MUL[RECIP_W-1:0];
    localparam logic               START_NEG   = (GOAL_DIFF < 0);

    localparam logic signed [ROWB_W-1:0] ROW_GAP_C = ROWB_W'(EDGE_GAP);
    localparam logic signed [ROWB_W-1:0] ROW_END_C = ROWB_W'(IMAGE_HEIGHT - EDGE_GAP);
    localparam logic signed [ROWB_W-1:0] ROW_MRG_C = ROWB_W'(bscc_pkg::ROW_MARGIN);
    localparam logic signed [COLB_W-1:0] COL_GAP_C = COLB_W'(EDGE_GAP);
    localparam logic signed [COLB_W-1:0] COL_END_C = COLB_W'(IMAGE_WIDTH - EDGE_GAP);
    localparam logic signed [COLB_W-1:0] COL_MRG_C = COLB_W'(bscc_pkg::ROW_MARGIN);
    localparam logic signed [BAND_W-1:0] BND_MRG_C = BAND_W'(bscc_pkg::ROW_MARGIN);

    logic [7:0]                   thr_reg;
    logic [bscc_pkg::ROW_W-1:0]   top_reg;
    logic [bscc_pkg::ROW_W-1:0]   bottom_reg;
    logic [bscc_pkg::COL_W-1:0]   ileft_reg;
    logic [bscc_pkg::COL_W-1:0]   iright_reg;
    logic [bscc_pkg::COL_W-1:0]   gleft_reg;
    logic [bscc_pkg::COL_W-1:0]   gright_reg;
    logic [bscc_pkg::SETTLE_W-1:0] settle_reg;
    logic [bscc_pkg::SETTLE_W-1:0] settle_next;

    logic signed [ROWB_W-1:0] lo_reg, lo_next;
    logic signed [ROWB_W-1:0] hi_reg, hi_next;
    logic signed [COLB_W-1:0] il_reg, il_next;
    logic signed [COLB_W-1:0] ir_reg, ir_next;
    logic signed [COLB_W-1:0] gl_reg, gl_next;
    logic signed [COLB_W-1:0] gr_reg, gr_next;
    logic signed [BAND_W-1:0] qs_reg, qs_next;
    logic signed [BAND_W-1:0] ql_reg, ql_next;
    logic signed [BAND_W-1:0] gs_reg, gs_next;
    logic signed [BAND_W-1:0] ge_reg, ge_next;

    logic signed [ROWB_W-1:0] top_m, bot_p, span_full;
    logic signed [COLB_W-1:0] il_m, ir_p, gl_m, gr_p;
    logic [SPAN_W-1:0]        span;
    logic [PROD_W-1:0]        prod_start, prod_len;
    logic signed [BAND_W-1:0] lo_band, hi_band, gs_raw, ge_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= bscc_pkg::RST_DIFF_THRESHOLD;
            top_reg    <= bscc_pkg::RST_FIELD_TOP_ROW;
            bottom_reg <= bscc_pkg::RST_FIELD_BOTTOM_ROW;
            ileft_reg  <= bscc_pkg::RST_INNER_LEFT_COL;
            iright_reg <= bscc_pkg::RST_INNER_RIGHT_COL;
            gleft_reg  <= bscc_pkg::RST_GOAL_LEFT_COL;
            gright_reg <= bscc_pkg::RST_GOAL_RIGHT_COL;
            settle_reg <= bscc_pkg::SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    bscc_pkg::CFG_DIFF_THRESHOLD:   thr_reg    <= wr_data[7:0];
                    bscc_pkg::CFG_FIELD_TOP_ROW:    top_reg    <= wr_data[bscc_pkg::ROW_W-1:0];
                    bscc_pkg::CFG_FIELD_BOTTOM_ROW: bottom_reg <= wr_data[bscc_pkg::ROW_W-1:0];
                    bscc_pkg::CFG_INNER_LEFT_COL:   ileft_reg  <= wr_data;
                    bscc_pkg::CFG_INNER_RIGHT_COL:  iright_reg <= wr_data;
                    bscc_pkg::CFG_GOAL_LEFT_COL:    gleft_reg  <= wr_data;
                    bscc_pkg::CFG_GOAL_RIGHT_COL:   gright_reg <= wr_data;
                    default:                        ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (wr_en)
        begin
            settle_next = bscc_pkg::SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // row and column bounds
    always_comb
    begin
        top_m   = signed'(ROWB_W'(top_reg)) - ROW_MRG_C;
        bot_p   = signed'(ROWB_W'(bottom_reg)) + ROW_MRG_C;
        lo_next = (top_m > ROW_GAP_C) ? top_m : ROW_GAP_C;
        hi_next = (bot_p < ROW_END_C) ? bot_p : ROW_END_C;
        il_m    = signed'(COLB_W'(ileft_reg)) - COL_MRG_C;
        ir_p    = signed'(COLB_W'(iright_reg)) + COL_MRG_C;
        gl_m    = signed'(COLB_W'(gleft_reg)) - COL_MRG_C;
        gr_p    = signed'(COLB_W'(gright_reg)) + COL_MRG_C;
        il_next = (il_m > COL_GAP_C) ? il_m : COL_GAP_C;
        ir_next = (ir_p < COL_END_C) ? ir_p : COL_END_C;
        gl_next = (gl_m > COL_GAP_C) ? gl_m : COL_GAP_C;
        gr_next = (gr_p < COL_END_C) ? gr_p : COL_END_C;
    end

    // goal band offsets by reciprocal multiply
    always_comb
    begin
        span_full  = hi_reg - lo_reg;
        span       = span_full[SPAN_W-1:0];
        prod_start = PROD_W'(span) * PROD_W'(START_MUL_C);
        prod_len   = PROD_W'(span) * PROD_W'(LEN_MUL_C);
        qs_next    = BAND_W'(prod_start >> bscc_pkg::RECIP_SHIFT);
        ql_next    = BAND_W'(prod_len >> bscc_pkg::RECIP_SHIFT);
    end

    // goal band rows, clipped to the field rows
    always_comb
    begin
        lo_band = BAND_W'(lo_reg);
        hi_band = BAND_W'(hi_reg);
        gs_raw  = (START_NEG ? (lo_band - qs_reg) : (lo_band + qs_reg)) - BND_MRG_C;
        ge_raw  = gs_raw + ql_reg + BND_MRG_C;
        gs_next = (gs_raw < lo_band) ? lo_band : gs_raw;
        ge_next = (ge_raw > hi_band) ? hi_band : ge_raw;
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        il_reg <= il_next;
        ir_reg <= ir_next;
        gl_reg <= gl_next;
        gr_reg <= gr_next;
        qs_reg <= qs_next;
        ql_reg <= ql_next;
        gs_reg <= gs_next;
        ge_reg <= ge_next;
    end

    always_comb
    begin
        win.lo          = lo_reg;
        win.hi          = hi_reg;
        win.gs          = gs_reg;
        win.ge          = ge_reg;
        win.inner_left  = il_reg;
        win.inner_right = ir_reg;
        win.goal_left   = gl_reg;
        win.goal_right  = gr_reg;
        win.threshold   = thr_reg;
        win.settled     = (settle_reg == '0);
    end

endmodule
